@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/hrs_pkg.sv @@
// Shared types, codes and text-matching helpers of the HTTP request header scanner.
package hrs_pkg;

  localparam int unsigned ResDepth = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_PATH  = 2'd1;
  localparam logic [1:0] TAG_HOST  = 2'd2;
  localparam logic [1:0] TAG_AGENT = 2'd3;

  localparam logic [1:0] METH_INVALID = 2'd0;
  localparam logic [1:0] METH_GET     = 2'd1;
  localparam logic [1:0] METH_POST    = 2'd2;

  localparam logic [2:0] VER_INVALID = 3'd0;
  localparam logic [2:0] VER_0_9     = 3'd1;
  localparam logic [2:0] VER_1_0     = 3'd2;
  localparam logic [2:0] VER_1_1     = 3'd3;
  localparam logic [2:0] VER_2_0     = 3'd4;
  localparam logic [2:0] VER_3_0     = 3'd5;

  // Keyword text, right-aligned in eleven bytes.
  localparam int unsigned TxtBits = 88;
  localparam logic [TxtBits-1:0] TXT_GET   = {64'd0, "GET"};
  localparam logic [TxtBits-1:0] TXT_POST  = {56'd0, "POST"};
  localparam logic [TxtBits-1:0] TXT_V09   = {24'd0, "HTTP/0.9"};
  localparam logic [TxtBits-1:0] TXT_V10   = {24'd0, "HTTP/1.0"};
  localparam logic [TxtBits-1:0] TXT_V11   = {24'd0, "HTTP/1.1"};
  localparam logic [TxtBits-1:0] TXT_V20   = {24'd0, "HTTP/2.0"};
  localparam logic [TxtBits-1:0] TXT_V30   = {24'd0, "HTTP/3.0"};
  localparam logic [TxtBits-1:0] TXT_HOST  = {48'd0, "Host:"};
  localparam logic [TxtBits-1:0] TXT_AGENT = "User-Agent:";

  localparam logic [3:0] LEN_GET     = 4'd3;
  localparam logic [3:0] LEN_POST    = 4'd4;
  localparam logic [3:0] LEN_VERSION = 4'd8;
  localparam logic [3:0] LEN_HOST    = 4'd5;
  localparam logic [3:0] LEN_AGENT   = 4'd11;
  localparam logic [3:0] POS_MAX     = 4'd15;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] token_tag;
    logic       byte_valid;
    logic       report_done;
    logic [1:0] method_code;
    logic [2:0] version_code;
    logic       host_found;
    logic       agent_found;
    logic       last_of_run;
  } res_t;

  function automatic logic gap_char(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
  endfunction

  // True when the keyword has byte b at position pos.
  function automatic logic char_match(input logic [TxtBits-1:0] text,
                                      input logic [3:0] len,
                                      input logic [3:0] pos,
                                      input logic [7:0] b);
    logic [3:0] idx;
    logic [6:0] bit_lo;
    idx    = len - 4'd1 - pos;
    bit_lo = {idx, 3'b000};
    return (pos < len) && (text[bit_lo +: 8] == b);
  endfunction

endpackage

@@ rtl/core/hrs_parser.sv @@
// Byte-wise request-line and header parser with a one-word output delay.
module hrs_parser import hrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output res_t       res_first,
  output res_t       res_second
);

  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_PATH    = 2'd1,
    PH_VERSION = 2'd2,
    PH_DONE    = 2'd3
  } word_phase_t;

  typedef enum logic [1:0] {
    LN_REQUEST = 2'd0,
    LN_HEAD    = 2'd1,
    LN_REST    = 2'd2
  } line_phase_t;

  word_phase_t parse_phase, parse_phase_next;
  line_phase_t line_phase, line_phase_next;
  logic [3:0]  char_position, char_position_next;
  logic [6:0]  word_match_flags, word_match_flags_next;
  logic [1:0]  header_match_flags, header_match_flags_next;
  logic [3:0]  header_position, header_position_next;
  logic [1:0]  capture_mode, capture_mode_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [1:0]  held_tag, held_tag_next;
  logic        held_valid, held_valid_next;
  logic [1:0]  method_found, method_found_next;
  logic [2:0]  version_found, version_found_next;
  logic [1:0]  found_flags, found_flags_next;
  logic        terminated, terminated_next;
  logic        prev_cr, prev_cr_next;

  logic       blank, nul, drop, old_valid;
  logic [1:0] cur_tag;
  logic       cur_valid;

  always_comb begin
    parse_phase_next        = parse_phase;
    line_phase_next         = line_phase;
    char_position_next      = char_position;
    word_match_flags_next   = word_match_flags;
    header_match_flags_next = header_match_flags;
    header_position_next    = header_position;
    capture_mode_next       = capture_mode;
    method_found_next       = method_found;
    version_found_next      = version_found;
    found_flags_next        = found_flags;
    terminated_next         = terminated;
    prev_cr_next            = prev_cr;
    cur_tag                 = TAG_NONE;
    cur_valid               = 1'b0;

    blank = gap_char(data_byte);
    nul   = (data_byte == CH_NUL);
    // drop a held agent CR once the LF that closes the value shows up
    drop  = held_valid && (held_tag == TAG_AGENT) && (held_byte == CH_CR) &&
            (capture_mode == TAG_AGENT) && (data_byte == CH_LF) && !terminated;
    old_valid = held_valid && !drop;

    if (!terminated) begin
      if (capture_mode == TAG_HOST) begin
        if (blank) capture_mode_next = TAG_NONE;
        else begin
          cur_tag   = TAG_HOST;
          cur_valid = 1'b1;
        end
      end else if (capture_mode == TAG_AGENT) begin
        if (drop || nul) capture_mode_next = TAG_NONE;
        else begin
          cur_tag   = TAG_AGENT;
          cur_valid = 1'b1;
        end
      end

      case (parse_phase)
        PH_METHOD: begin
          if (!blank) begin
            word_match_flags_next[0] = word_match_flags[0] &
                char_match(TXT_GET, LEN_GET, char_position, data_byte);
            word_match_flags_next[1] = word_match_flags[1] &
                char_match(TXT_POST, LEN_POST, char_position, data_byte);
            if (char_position < POS_MAX) char_position_next = char_position + 4'd1;
          end else begin
            if (word_match_flags[0] && char_position == LEN_GET)
              method_found_next = METH_GET;
            else if (word_match_flags[1] && char_position == LEN_POST)
              method_found_next = METH_POST;
            else
              method_found_next = METH_INVALID;
            parse_phase_next   = PH_PATH;
            char_position_next = 4'd0;
          end
        end
        PH_PATH: begin
          if (!blank) begin
            cur_tag   = TAG_PATH;
            cur_valid = 1'b1;
          end else begin
            parse_phase_next      = PH_VERSION;
            char_position_next    = 4'd0;
            word_match_flags_next = '1;
          end
        end
        PH_VERSION: begin
          if (!blank) begin
            word_match_flags_next[2] = word_match_flags[2] &
                char_match(TXT_V09, LEN_VERSION, char_position, data_byte);
            word_match_flags_next[3] = word_match_flags[3] &
                char_match(TXT_V10, LEN_VERSION, char_position, data_byte);
            word_match_flags_next[4] = word_match_flags[4] &
                char_match(TXT_V11, LEN_VERSION, char_position, data_byte);
            word_match_flags_next[5] = word_match_flags[5] &
                char_match(TXT_V20, LEN_VERSION, char_position, data_byte);
            word_match_flags_next[6] = word_match_flags[6] &
                char_match(TXT_V30, LEN_VERSION, char_position, data_byte);
            if (char_position < POS_MAX) char_position_next = char_position + 4'd1;
          end else begin
            version_found_next = VER_INVALID;
            if (char_position == LEN_VERSION) begin
              if (word_match_flags[2])      version_found_next = VER_0_9;
              else if (word_match_flags[3]) version_found_next = VER_1_0;
              else if (word_match_flags[4]) version_found_next = VER_1_1;
              else if (word_match_flags[5]) version_found_next = VER_2_0;
              else if (word_match_flags[6]) version_found_next = VER_3_0;
            end
            parse_phase_next = PH_DONE;
          end
        end
        default: ;
      endcase

      if (line_phase == LN_HEAD) begin
        if (!blank) begin
          header_match_flags_next[0] = header_match_flags[0] &
              char_match(TXT_HOST, LEN_HOST, header_position, data_byte);
          header_match_flags_next[1] = header_match_flags[1] &
              char_match(TXT_AGENT, LEN_AGENT, header_position, data_byte);
          if (header_position < POS_MAX) header_position_next = header_position + 4'd1;
        end else begin
          // start a capture only if no value is still running
          if (capture_mode_next == TAG_NONE && !nul) begin
            if (header_match_flags[0] && header_position == LEN_HOST && !found_flags[0]) begin
              found_flags_next[0] = 1'b1;
              capture_mode_next   = TAG_HOST;
            end else if (header_match_flags[1] && header_position == LEN_AGENT &&
                         !found_flags[1]) begin
              found_flags_next[1] = 1'b1;
              capture_mode_next   = TAG_AGENT;
            end
          end
          line_phase_next = LN_REST;
        end
      end
      if (prev_cr && data_byte == CH_LF) begin
        line_phase_next         = LN_HEAD;
        header_position_next    = 4'd0;
        header_match_flags_next = '1;
      end
      prev_cr_next = (data_byte == CH_CR);

      if (nul) begin
        terminated_next   = 1'b1;
        capture_mode_next = TAG_NONE;
      end
    end

    res_first.out_byte     = old_valid ? held_byte : 8'd0;
    res_first.token_tag    = old_valid ? held_tag : TAG_NONE;
    res_first.byte_valid   = old_valid;
    res_first.report_done  = 1'b0;
    res_first.method_code  = METH_INVALID;
    res_first.version_code = VER_INVALID;
    res_first.host_found   = 1'b0;
    res_first.agent_found  = 1'b0;
    res_first.last_of_run  = !end_of_message;

    res_second.out_byte     = cur_valid ? data_byte : 8'd0;
    res_second.token_tag    = cur_valid ? cur_tag : TAG_NONE;
    res_second.byte_valid   = cur_valid;
    res_second.report_done  = 1'b1;
    res_second.method_code  = method_found_next;
    res_second.version_code = version_found_next;
    res_second.host_found   = found_flags_next[0];
    res_second.agent_found  = found_flags_next[1];
    res_second.last_of_run  = 1'b1;

    held_byte_next  = cur_valid ? data_byte : 8'd0;
    held_tag_next   = cur_valid ? cur_tag : TAG_NONE;
    held_valid_next = cur_valid;

    // return to the idle state after the final word of a message
    if (end_of_message) begin
      parse_phase_next        = PH_METHOD;
      line_phase_next         = LN_REQUEST;
      char_position_next      = 4'd0;
      word_match_flags_next   = '1;
      header_match_flags_next = '1;
      header_position_next    = 4'd0;
      capture_mode_next       = TAG_NONE;
      method_found_next       = METH_INVALID;
      version_found_next      = VER_INVALID;
      found_flags_next        = 2'd0;
      terminated_next         = 1'b0;
      prev_cr_next            = 1'b0;
      held_byte_next          = 8'd0;
      held_tag_next           = TAG_NONE;
      held_valid_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_METHOD;
      line_phase         <= LN_REQUEST;
      char_position      <= 4'd0;
      word_match_flags   <= '1;
      header_match_flags <= '1;
      header_position    <= 4'd0;
      capture_mode       <= TAG_NONE;
      method_found       <= METH_INVALID;
      version_found      <= VER_INVALID;
      found_flags        <= 2'd0;
      terminated         <= 1'b0;
      prev_cr            <= 1'b0;
      held_byte          <= 8'd0;
      held_tag           <= TAG_NONE;
      held_valid         <= 1'b0;
    end else if (accept) begin
      parse_phase        <= parse_phase_next;
      line_phase         <= line_phase_next;
      char_position      <= char_position_next;
      word_match_flags   <= word_match_flags_next;
      header_match_flags <= header_match_flags_next;
      header_position    <= header_position_next;
      capture_mode       <= capture_mode_next;
      method_found       <= method_found_next;
      version_found      <= version_found_next;
      found_flags        <= found_flags_next;
      terminated         <= terminated_next;
      prev_cr            <= prev_cr_next;
      held_byte          <= held_byte_next;
      held_tag           <= held_tag_next;
      held_valid         <= held_valid_next;
    end
  end

endmodule

@@ rtl/core/hrs_res_fifo.sv @@
// Result queue that takes one or two results per input word and hands out one per cycle while rd_ready is high.
module hrs_res_fifo import hrs_pkg::*; #(
  parameter int unsigned Depth = ResDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_two,
  input  res_t wr_first,
  input  res_t wr_second,
  output logic room,
  output logic rd_valid,
  input  logic rd_ready,
  output res_t rd_data
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_alt;

  assign pop        = rd_valid && rd_ready;
  assign rd_valid   = (count != '0);
  assign rd_data    = mem[rd_ptr];
  // keep space for the two results of a final word
  assign room       = (count <= CntW'(Depth - 2));
  assign wr_ptr_alt = wr_ptr + PtrW'(1);

  always_comb begin
    count_next = count;
    if (push) count_next = count_next + (push_two ? CntW'(2) : CntW'(1));
    if (pop)  count_next = count_next - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_first;
      if (push_two) mem[wr_ptr_alt] <= wr_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= push_two ? wr_ptr + PtrW'(2) : wr_ptr_alt;
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      count <= count_next;
    end
  end

endmodule

@@ rtl/core/http_request_header_scanner.sv @@
// Top level of the HTTP request header scanner.
// A result is registered in the result queue before it is offered.
// Throughput: one word per cycle while req_ready is high; a word with end_of_message
// yields two results, drained one per cycle while rsp_ready is high from a four-entry result queue.
// Each emitted byte leaves with the result of the following word, or in the second result of a final word.
// Synchronous reset returns the parser to the start of a request and empties the queue.
`include "assert_macros.svh"

module http_request_header_scanner import hrs_pkg::*; #(
  parameter int unsigned ResQueueDepth = ResDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] out_byte,
  output logic [1:0] token_tag,
  output logic       byte_valid,
  output logic       report_done,
  output logic [1:0] method_code,
  output logic [2:0] version_code,
  output logic       host_found,
  output logic       agent_found,
  output logic       last_of_run
);

  logic accept;
  res_t res_first, res_second, rsp;

  assign accept = req_valid && req_ready;

  hrs_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .res_first      (res_first),
    .res_second     (res_second)
  );

  hrs_res_fifo #(
    .Depth (ResQueueDepth)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_two  (end_of_message),
    .wr_first  (res_first),
    .wr_second (res_second),
    .room      (req_ready),
    .rd_valid  (rsp_valid),
    .rd_ready  (rsp_ready),
    .rd_data   (rsp)
  );

  assign out_byte     = rsp.out_byte;
  assign token_tag    = rsp.token_tag;
  assign byte_valid   = rsp.byte_valid;
  assign report_done  = rsp.report_done;
  assign method_code  = rsp.method_code;
  assign version_code = rsp.version_code;
  assign host_found   = rsp.host_found;
  assign agent_found  = rsp.agent_found;
  assign last_of_run  = rsp.last_of_run;

  `ASSERT_NEXT(a_accept_gives_result, accept, rsp_valid, "accepted word produced no result")
  `ASSERT_SAME(a_report_is_last, rsp_valid && report_done, last_of_run, "report not last of run")
  `ASSERT_SAME(a_empty_byte_zero, rsp_valid && !byte_valid, out_byte == 8'd0 && token_tag == TAG_NONE, "unused byte fields not cleared")
  `ASSERT_SAME(a_no_report_zero, rsp_valid && !report_done, method_code == METH_INVALID && version_code == VER_INVALID && !host_found && !agent_found, "report fields set without report")

endmodule

@@ bench/http_request_header_scanner_test.sv @@
// Self-checking bench for the HTTP request header scanner: directed and random requests, predicted results.
module http_request_header_scanner_test import hrs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {WORD_METHOD, WORD_PATH, WORD_VERSION, WORD_DONE} req_word_t;
  typedef enum logic [1:0] {LINE_REQUEST, LINE_HEAD_WORD, LINE_REST} line_state_t;
  typedef enum int {
    KW_GET, KW_POST, KW_V09, KW_V10, KW_V11, KW_V20, KW_V30, KW_HOST, KW_AGENT
  } keyword_t;

  class header_scan_board;
    res_t expected_results[$];
    int errors, checked, parsed_words, messages;
    int get_reports, post_reports, host_reports, agent_reports;

    req_word_t   word_phase;
    logic [3:0]  word_pos;
    logic [6:0]  word_cand;
    line_state_t line_state;
    logic [3:0]  head_pos;
    logic [1:0]  head_cand;
    logic [1:0]  capture;
    logic [7:0]  held_byte;
    logic [1:0]  held_tag;
    logic        held_valid;
    logic [1:0]  method;
    logic [2:0]  version;
    logic        host_seen, agent_seen, stopped, after_cr;

    function new();
      clear();
    endfunction

    function void clear();
      word_phase = WORD_METHOD;
      word_pos   = '0;
      word_cand  = '1;
      line_state = LINE_REQUEST;
      head_pos   = '0;
      head_cand  = '1;
      capture    = TAG_NONE;
      held_byte  = '0;
      held_tag   = TAG_NONE;
      held_valid = 1'b0;
      method     = METH_INVALID;
      version    = VER_INVALID;
      host_seen  = 1'b0;
      agent_seen = 1'b0;
      stopped    = 1'b0;
      after_cr   = 1'b0;
    endfunction

    static function string keyword(int idx);
      case (idx)
        KW_GET:  return "GET";
        KW_POST: return "POST";
        KW_V09:  return "HTTP/0.9";
        KW_V10:  return "HTTP/1.0";
        KW_V11:  return "HTTP/1.1";
        KW_V20:  return "HTTP/2.0";
        KW_V30:  return "HTTP/3.0";
        KW_HOST: return "Host:";
        default: return "User-Agent:";
      endcase
    endfunction

    function bit keyword_has(int idx, logic [3:0] pos, logic [7:0] b);
      string s;
      logic [7:0] c;
      s = keyword(idx);
      if (pos >= s.len()) return 1'b0;
      c = s[pos];
      return c == b;
    endfunction

    function res_t make_result(logic [7:0] b, logic [1:0] tag, logic v, logic done,
                               logic last);
      res_t r;
      r.out_byte     = v ? b : 8'd0;
      r.token_tag    = v ? tag : TAG_NONE;
      r.byte_valid   = v;
      r.report_done  = done;
      r.method_code  = done ? method : METH_INVALID;
      r.version_code = done ? version : VER_INVALID;
      r.host_found   = done & host_seen;
      r.agent_found  = done & agent_seen;
      r.last_of_run  = last;
      return r;
    endfunction

    // Advance the scanner by one request byte and queue the results it causes.
    function void note_word(logic [7:0] b, logic eom);
      logic [7:0] ob;
      logic [1:0] ot, tag;
      logic ov, emit, gap, nul, drop;
      ob   = held_byte;
      ot   = held_tag;
      ov   = held_valid;
      tag  = TAG_NONE;
      emit = 1'b0;
      // a held agent CR followed by LF closes the value and is dropped
      drop = held_valid && held_tag == TAG_AGENT && held_byte == CH_CR &&
             capture == TAG_AGENT && b == CH_LF && !stopped;
      if (drop) ov = 1'b0;
      if (!stopped) begin
        parsed_words++;
        gap = (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
        nul = (b == CH_NUL);
        if (capture == TAG_HOST) begin
          if (gap) capture = TAG_NONE;
          else begin
            tag  = TAG_HOST;
            emit = 1'b1;
          end
        end else if (capture == TAG_AGENT) begin
          if (drop || nul) capture = TAG_NONE;
          else begin
            tag  = TAG_AGENT;
            emit = 1'b1;
          end
        end
        case (word_phase)
          WORD_METHOD: begin
            if (!gap) begin
              for (int i = 0; i < 2; i++)
                if (!keyword_has(KW_GET + i, word_pos, b)) word_cand[i] = 1'b0;
              if (word_pos != POS_MAX) word_pos++;
            end else begin
              if (word_cand[0] && word_pos == LEN_GET) method = METH_GET;
              else if (word_cand[1] && word_pos == LEN_POST) method = METH_POST;
              else method = METH_INVALID;
              word_phase = WORD_PATH;
              word_pos   = '0;
            end
          end
          WORD_PATH: begin
            if (!gap) begin
              tag  = TAG_PATH;
              emit = 1'b1;
            end else begin
              word_phase = WORD_VERSION;
              word_pos   = '0;
              word_cand  = '1;
            end
          end
          WORD_VERSION: begin
            if (!gap) begin
              for (int i = 0; i < 5; i++)
                if (!keyword_has(KW_V09 + i, word_pos, b)) word_cand[2 + i] = 1'b0;
              if (word_pos != POS_MAX) word_pos++;
            end else begin
              version = VER_INVALID;
              // lowest matching candidate wins
              if (word_pos == LEN_VERSION)
                for (int i = 4; i >= 0; i--)
                  if (word_cand[2 + i]) version = VER_0_9 + 3'(i);
              word_phase = WORD_DONE;
            end
          end
          default: ;
        endcase
        if (line_state == LINE_HEAD_WORD) begin
          if (!gap) begin
            if (!keyword_has(KW_HOST, head_pos, b)) head_cand[0] = 1'b0;
            if (!keyword_has(KW_AGENT, head_pos, b)) head_cand[1] = 1'b0;
            if (head_pos != POS_MAX) head_pos++;
          end else begin
            if (capture == TAG_NONE && !nul) begin
              if (head_cand[0] && head_pos == LEN_HOST && !host_seen) begin
                host_seen = 1'b1;
                capture   = TAG_HOST;
              end else if (head_cand[1] && head_pos == LEN_AGENT && !agent_seen) begin
                agent_seen = 1'b1;
                capture    = TAG_AGENT;
              end
            end
            line_state = LINE_REST;
          end
        end
        if (after_cr && b == CH_LF) begin
          line_state = LINE_HEAD_WORD;
          head_pos   = '0;
          head_cand  = '1;
        end
        after_cr = (b == CH_CR);
        if (nul) begin
          stopped = 1'b1;
          capture = TAG_NONE;
        end
      end
      if (eom) begin
        expected_results.push_back(make_result(ob, ot, ov, 1'b0, 1'b0));
        expected_results.push_back(make_result(b, tag, emit, 1'b1, 1'b1));
        messages++;
        clear();
      end else begin
        expected_results.push_back(make_result(ob, ot, ov, 1'b0, 1'b1));
        held_byte  = emit ? b : 8'd0;
        held_tag   = emit ? tag : TAG_NONE;
        held_valid = emit;
      end
    endfunction

    task report_mismatch(string what, int got_v, int want_v);
      $display("mismatch at result %0d: %s got %0h expected %0h", checked, what, got_v, want_v);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, out_byte", got.out_byte, 0);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.out_byte != want.out_byte) report_mismatch("out_byte", got.out_byte, want.out_byte);
      if (got.token_tag != want.token_tag)
        report_mismatch("token_tag", got.token_tag, want.token_tag);
      if (got.byte_valid != want.byte_valid)
        report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
      if (got.report_done != want.report_done)
        report_mismatch("report_done", got.report_done, want.report_done);
      if (got.method_code != want.method_code)
        report_mismatch("method_code", got.method_code, want.method_code);
      if (got.version_code != want.version_code)
        report_mismatch("version_code", got.version_code, want.version_code);
      if (got.host_found != want.host_found)
        report_mismatch("host_found", got.host_found, want.host_found);
      if (got.agent_found != want.agent_found)
        report_mismatch("agent_found", got.agent_found, want.agent_found);
      if (got.last_of_run != want.last_of_run)
        report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
      if (want.report_done) begin
        if (want.method_code == METH_GET) get_reports++;
        if (want.method_code == METH_POST) post_reports++;
        if (want.host_found) host_reports++;
        if (want.agent_found) agent_reports++;
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic       end_of_message = 1'b0;
  logic       rsp_ready = 1'b0;
  logic       req_ready, rsp_valid;
  logic [7:0] out_byte;
  logic [1:0] token_tag, method_code;
  logic [2:0] version_code;
  logic       byte_valid, report_done, host_found, agent_found, last_of_run;

  header_scan_board board;
  logic [7:0] msg_bytes[$];
  bit idle_on = 1'b1;
  bit stall_request = 1'b0;
  int stall_left = 0;
  int sent_words = 0;

  http_request_header_scanner i_dut (.*);

  always #10 clk = ~clk;

  // Result side: check taken results, then pick the next ready level.
  initial begin
    res_t got;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        got = '{out_byte, token_tag, byte_valid, report_done, method_code, version_code,
                host_found, agent_found, last_of_run};
        board.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (stall_request) begin
        // hold off long enough for the result queue to back up into the input
        stall_request = 1'b0;
        stall_left = 80;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !(idle_on && $urandom_range(99) < 9);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eom);
    if (idle_on && $urandom_range(99) < 9) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid      <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (!req_ready);
    board.note_word(b, eom);
    sent_words++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_word(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (board.expected_results.size() != 0);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_SPACE || c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  function automatic void add_word(int n);
    repeat (n) msg_bytes.push_back(word_char());
  endfunction

  function automatic void add_sep();
    int r;
    r = $urandom_range(99);
    if (r < 88) msg_bytes.push_back(CH_SPACE);
    else if (r < 94) msg_bytes.push_back(CH_CR);
    else msg_bytes.push_back(CH_LF);
  endfunction

  function automatic void add_line_end();
    int r;
    r = $urandom_range(99);
    if (r < 88) begin
      msg_bytes.push_back(CH_CR);
      msg_bytes.push_back(CH_LF);
    end else if (r < 94) begin
      msg_bytes.push_back(CH_CR);
    end else begin
      msg_bytes.push_back(CH_LF);
    end
  endfunction

  // Mostly well-formed requests with random content, some noise and broken ones.
  function automatic void build_request();
    int r, n;
    msg_bytes.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 16)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    r = $urandom_range(99);
    if (r < 40) add_text("GET");
    else if (r < 75) add_text("POST");
    else if (r < 83) add_word($urandom_range(1, 5));
    else if (r < 90) begin
      if (r[0]) add_text("GE");
      else add_text("POS");
      add_word(1);
    end else if (r < 96) add_word($urandom_range(15, 18));
    add_sep();
    add_word($urandom_range(0, 6));
    msg_bytes.push_back(CH_SPACE);
    r = $urandom_range(99);
    if (r < 78) begin
      add_text(board.keyword(KW_V09 + $urandom_range(4)));
    end else if (r < 86) begin
      add_text(board.keyword(KW_V09 + $urandom_range(4)));
      msg_bytes[$] = word_char();
    end else if (r < 92) begin
      add_text("HTTP/1.");
    end else begin
      add_text("HTTP/1.1");
      add_word($urandom_range(1, 9));
    end
    add_line_end();
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(99);
      if (r < 35) add_text("Host:");
      else if (r < 70) add_text("User-Agent:");
      else if (r < 78) add_text("Host");
      else if (r < 84) add_text("user-agent:");
      else if (r < 88) add_text("Host:x");
      else add_word($urandom_range(1, 12));
      if ($urandom_range(99) < 12) begin
        // header word ends the line: a User-Agent capture that starts here runs across it
        msg_bytes.push_back(CH_CR);
        msg_bytes.push_back(CH_LF);
      end else begin
        msg_bytes.push_back(CH_SPACE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          r = $urandom_range(99);
          if (r < 80) msg_bytes.push_back(word_char());
          else if (r < 90) msg_bytes.push_back(CH_SPACE);
          else if (r < 96) msg_bytes.push_back(CH_CR);
          else msg_bytes.push_back(CH_LF);
        end
        add_line_end();
      end
    end
    if ($urandom_range(1)) begin
      msg_bytes.push_back(CH_CR);
      msg_bytes.push_back(CH_LF);
      add_word($urandom_range(0, 6));
    end
    if ($urandom_range(99) < 25) begin
      msg_bytes.push_back(CH_NUL);
      repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
    end
  endfunction

  initial begin
    int m;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // POST with a top-bit path byte, HTTP/3.0, then NUL and a byte that is ignored
    msg_bytes.delete();
    add_text("POST ");
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(CH_SPACE);
    add_text("HTTP/3.0");
    msg_bytes.push_back(CH_CR);
    msg_bytes.push_back(CH_LF);
    msg_bytes.push_back(CH_NUL);
    msg_bytes.push_back(8'h01);
    send_message();
    // single-byte message ending on a CR
    msg_bytes.delete();
    msg_bytes.push_back(CH_CR);
    send_message();
    wait_drained();

    m = 0;
    while (sent_words < 440) begin
      idle_on = !(m >= 8 && m < 14);
      if (m == 3) stall_request = 1'b1;
      if (m % 7 == 6) wait_drained();
      build_request();
      send_message();
      m++;
    end
    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d requests, %0d words sent, %0d parsed bytes, %0d results compared",
             board.messages, sent_words, board.parsed_words, board.checked);
    $display("reports: %0d GET, %0d POST, %0d with Host, %0d with User-Agent, %0d mismatches",
             board.get_reports, board.post_reports, board.host_reports,
             board.agent_reports, board.errors);
    if (board.errors == 0 && board.expected_results.size() == 0)
      $display("http_request_header_scanner verification clean");
    else
      $display("http_request_header_scanner verification failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results pending", board.expected_results.size());
    $display("http_request_header_scanner verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hrs_pkg.sv
rtl/core/hrs_parser.sv
rtl/core/hrs_res_fifo.sv
rtl/core/http_request_header_scanner.sv
bench/http_request_header_scanner_test.sv
